>>> hw/rtl/bws_pkg.sv
package bws_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SAMPLE_PORT_BITS = 32;
  localparam int SUM_BITS         = 40;

  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_BITS     = 16;
  localparam int WINDOW_REG_BITS = 5;

  localparam logic [WIDTH_REG_BITS-1:0]  IMAGE_WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0]     IMAGE_HEIGHT_RESET = 16'd1024;
  localparam logic [WINDOW_REG_BITS-1:0] WINDOW_SIZE_RESET  = 5'd3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_WINDOW_SIZE  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] window_sum;
    logic                       row_last;
    logic                       frame_last;
  } result_t;

endpackage

>>> hw/rtl/bws_if.sv
interface bws_sample_if;
  logic                                            valid;
  logic                                            ready;
  logic signed [bws_pkg::SAMPLE_PORT_BITS-1:0]     sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface bws_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bws_pkg::SUM_BITS-1:0]   window_sum;
  logic                                  row_last;
  logic                                  frame_last;

  modport source (output valid, output window_sum, output row_last, output frame_last,
                  input ready);
  modport sink (input valid, input window_sum, input row_last, input frame_last,
                output ready);
endinterface

interface bws_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [bws_pkg::CFG_INDEX_BITS-1:0]    index;
  logic [bws_pkg::CFG_DATA_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/box_window_sum_2d_unit.sv
// 2-D box filter over a raster stream: each accepted sample updates a running
// horizontal sum of the last window_size samples of its row (a shift line of
// sample cells supplies the sample leaving the window) and a running vertical
// sum per output column, kept in a column-sum RAM and a line RAM of recent
// horizontal sums. One sample is taken every clock; a result, when the sample
// completes a full window, passes the vertical stage register and then a
// three-entry output queue, so input stalls only when that queue backs up.
// The rate is set by the read-modify-write of each RAM, with the
// last write forwarded to the next read. Any register write restarts the
// frame position; write registers only while no results are pending. A
// window wider or taller than the image gives no results at all.
module box_window_sum_2d_unit #(
  parameter int MAX_WIDTH   = bws_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW  = bws_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = bws_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bws_sample_if.sink    pixels,
  bws_result_if.source  sums,
  bws_cfg_if.sink       cfg
);

  localparam int SUMB   = bws_pkg::SUM_BITS;
  localparam int SB     = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam int GROW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0;
  localparam int RW     = (SB + GROW < SUMB) ? SB + GROW : SUMB;
  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WB     = $clog2(MAX_WIDTH + 1);
  localparam int TB     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int HB     = bws_pkg::HEIGHT_BITS;
  localparam int LDEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int LAB    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int QDEPTH = 3;
  localparam int QB     = $clog2(QDEPTH);

  // configuration
  logic [bws_pkg::WIDTH_REG_BITS-1:0]  width_reg;
  logic [HB-1:0]                       height_reg;
  logic [bws_pkg::WINDOW_REG_BITS-1:0] window_reg;
  logic                                cfg_hit;

  assign cfg.ready = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg.valid) begin
      case (cfg.index)
        bws_pkg::CFG_IMAGE_WIDTH,
        bws_pkg::CFG_IMAGE_HEIGHT,
        bws_pkg::CFG_WINDOW_SIZE: cfg_hit = 1'b1;
        default:                  cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= bws_pkg::IMAGE_WIDTH_RESET;
      height_reg <= bws_pkg::IMAGE_HEIGHT_RESET;
      window_reg <= bws_pkg::WINDOW_SIZE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        bws_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg.data[bws_pkg::WIDTH_REG_BITS-1:0];
        bws_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg.data[HB-1:0];
        bws_pkg::CFG_WINDOW_SIZE:  window_reg <= cfg.data[bws_pkg::WINDOW_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [WB-1:0]                       w_eff;
  logic [HB-1:0]                       h_eff;
  logic [bws_pkg::WINDOW_REG_BITS-1:0] d_eff;
  logic                                active;

  always_comb begin
    if (width_reg == '0) begin
      w_eff = WB'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(width_reg);
    end
    h_eff  = (height_reg == '0) ? HB'(1) : height_reg;
    d_eff  = (window_reg == '0) ? 5'd1 : window_reg;
    active = (32'(d_eff) <= MAX_WINDOW) && (32'(d_eff) <= 32'(w_eff))
          && (32'(d_eff) <= 32'(h_eff));
  end

  // frame position
  logic [CW-1:0] col_cnt;
  logic [HB-1:0] row_cnt;
  logic [TB-1:0] row_slot;
  logic          accept;
  logic          last_col, last_row, col_full, row_full, sub_h, sub_v;
  logic [CW-1:0] k;
  logic [TB-1:0] read_slot;
  logic [LAB-1:0] line_rd_addr, line_wr_addr;

  assign accept = pixels.valid && pixels.ready;

  always_comb begin
    last_col = (32'(col_cnt) + 32'd1 == 32'(w_eff));
    last_row = (32'(row_cnt) + 32'd1 == 32'(h_eff));
    col_full = (32'(col_cnt) + 32'd1 >= 32'(d_eff));
    row_full = (32'(row_cnt) + 32'd1 >= 32'(d_eff));
    sub_h    = (32'(col_cnt) >= 32'(d_eff));
    sub_v    = (32'(row_cnt) >= 32'(d_eff));
    k        = CW'(32'(col_cnt) + 32'd1 - 32'(d_eff));
    if (32'(row_slot) >= 32'(d_eff)) begin
      read_slot = TB'(32'(row_slot) - 32'(d_eff));
    end else begin
      read_slot = TB'(32'(row_slot) + MAX_WINDOW - 32'(d_eff));
    end
    line_rd_addr = LAB'(32'(read_slot) * MAX_WIDTH + 32'(k));
    line_wr_addr = LAB'(32'(row_slot) * MAX_WIDTH + 32'(k));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      row_slot <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt <= '0;
        if (last_row) begin
          row_cnt  <= '0;
          row_slot <= '0;
        end else begin
          row_cnt  <= row_cnt + HB'(1);
          row_slot <= (32'(row_slot) == MAX_WINDOW - 1) ? '0 : row_slot + TB'(1);
        end
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // horizontal window: shift line of recent samples
  logic signed [SB-1:0] s_bits;
  logic        [SB-1:0] taps [MAX_WINDOW];
  logic        [TB-1:0] tap_idx;
  logic signed [SB-1:0] tap_val;

  assign s_bits  = pixels.sample[SB-1:0];
  assign tap_idx = TB'(d_eff - 5'd1);
  assign tap_val = taps[tap_idx];

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    if (j == 0) begin : g_head
      bws_cell #(.WIDTH(SB)) u_cell (
        .clk(clk), .shift(accept), .d(s_bits), .q(taps[j])
      );
    end else begin : g_body
      bws_cell #(.WIDTH(SB)) u_cell (
        .clk(clk), .shift(accept), .d(taps[j-1]), .q(taps[j])
      );
    end
  end

  logic signed [RW-1:0]   rws;
  logic signed [SUMB-1:0] hs_full;

  always_comb begin
    hs_full = ((col_cnt == '0) ? '0 : SUMB'(rws))
            - (sub_h ? SUMB'(tap_val) : '0)
            + SUMB'(s_bits);
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      rws <= RW'(hs_full);
    end
  end

  // vertical stage
  logic                 s1_valid, s1_produce;
  logic                 s1_first_row, s1_sub_v, s1_row_last, s1_frame_last;
  logic signed [RW-1:0] s1_hs;
  logic [CW-1:0]        s1_k;
  logic [LAB-1:0]       s1_line_rd, s1_line_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1_produce <= 1'b0;
    end else begin
      s1_valid   <= accept && active && col_full;
      s1_produce <= accept && active && col_full && row_full;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first_row  <= (row_cnt == '0);
      s1_sub_v      <= sub_v;
      s1_row_last   <= last_col;
      s1_frame_last <= last_col && last_row;
      s1_hs         <= RW'(hs_full);
      s1_k          <= k;
      s1_line_rd    <= line_rd_addr;
      s1_line_wr    <= line_wr_addr;
    end
  end

  logic [SUMB-1:0]        col_rd;
  logic [RW-1:0]          line_rd;
  logic signed [SUMB-1:0] col_prev, col_new;
  logic signed [RW-1:0]   line_prev;

  // last write to each RAM, for a read that was issued in the same cycle
  logic                  fwd_col_valid, fwd_line_valid;
  logic [CW-1:0]         fwd_col_addr;
  logic [SUMB-1:0]       fwd_col_data;
  logic [LAB-1:0]        fwd_line_addr;
  logic [RW-1:0]         fwd_line_data;

  bws_ram #(.WIDTH(SUMB), .DEPTH(MAX_WIDTH), .ADDR_BITS(CW)) u_col_ram (
    .clk(clk), .we(s1_valid), .wr_addr(s1_k), .wr_data(col_new),
    .re(accept), .rd_addr(k), .rd_data(col_rd)
  );

  bws_ram #(.WIDTH(RW), .DEPTH(LDEPTH), .ADDR_BITS(LAB)) u_line_ram (
    .clk(clk), .we(s1_valid), .wr_addr(s1_line_wr), .wr_data(s1_hs),
    .re(accept), .rd_addr(line_rd_addr), .rd_data(line_rd)
  );

  always_comb begin
    col_prev  = (fwd_col_valid && fwd_col_addr == s1_k) ? fwd_col_data : col_rd;
    line_prev = (fwd_line_valid && fwd_line_addr == s1_line_rd) ? fwd_line_data : line_rd;
    col_new   = (s1_first_row ? '0 : col_prev)
              - (s1_sub_v ? SUMB'(line_prev) : '0)
              + SUMB'(s1_hs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_col_valid  <= 1'b0;
      fwd_line_valid <= 1'b0;
    end else if (s1_valid) begin
      fwd_col_valid  <= 1'b1;
      fwd_line_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fwd_col_addr  <= s1_k;
      fwd_col_data  <= col_new;
      fwd_line_addr <= s1_line_wr;
      fwd_line_data <= s1_hs;
    end
  end

  // output queue
  bws_pkg::result_t queue [QDEPTH];
  logic [QB-1:0]    wr_ptr, rd_ptr;
  logic [QB:0]      count;
  logic             pop;

  assign pop          = sums.valid && sums.ready;
  assign sums.valid   = (count != '0);
  assign pixels.ready = (32'(count) + 32'(s1_produce) < QDEPTH);

  assign sums.window_sum = queue[rd_ptr].window_sum;
  assign sums.row_last   = queue[rd_ptr].row_last;
  assign sums.frame_last = queue[rd_ptr].frame_last;

  always_ff @(posedge clk) begin
    if (s1_produce) begin
      queue[wr_ptr] <= '{window_sum: col_new, row_last: s1_row_last,
                         frame_last: s1_frame_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1_produce) begin
        wr_ptr <= (32'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + QB'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + QB'(1);
      end
      count <= count + (QB+1)'(s1_produce) - (QB+1)'(pop);
    end
  end

endmodule

>>> hw/rtl/bws_cell.sv
module bws_cell #(
  parameter int WIDTH = bws_pkg::SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= d;
    end
  end

  assign q = held;

endmodule

>>> hw/rtl/bws_ram.sv
module bws_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/bws_checker.sv
module bws_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                res_valid,
  input logic                                res_ready,
  input logic signed [bws_pkg::SUM_BITS-1:0] window_sum,
  input logic                                row_last,
  input logic                                frame_last
);

  // queue is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a waiting result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(window_sum)
      && $stable(row_last) && $stable(frame_last))
    else $error("stalled result changed");

  // end of frame is always end of a row
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_last |-> row_last)
    else $error("frame_last without row_last");

  // a result showing up in an empty queue comes from an accepted request
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a request two cycles earlier");

endmodule

bind box_window_sum_2d_unit bws_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pixels.valid),
  .in_ready   (pixels.ready),
  .res_valid  (sums.valid),
  .res_ready  (sums.ready),
  .window_sum (sums.window_sum),
  .row_last   (sums.row_last),
  .frame_last (sums.frame_last)
);
